// ===== design/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// Types, codes and the nibble decode step of the 4-bit pixel string decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

  // Depth of the queue between the byte parser and the run placer.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] AREA_LINES_RESET = 16'd576;

  // Data type bytes seen while the parser is idle.
  localparam logic [7:0] DT_STRING_4BIT = 8'h11;
  localparam logic [7:0] DT_SKIP_ONE    = 8'h00;
  localparam logic [7:0] DT_END_OF_LINE = 8'hF0;

  // Parser phase codes.
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_SKIP = 4'd1;
  localparam logic [3:0] PH_CODE = 4'd2;
  localparam logic [3:0] PH_SW   = 4'd3;
  localparam logic [3:0] PH_C4   = 4'd4;
  localparam logic [3:0] PH_L9   = 4'd5;
  localparam logic [3:0] PH_C9   = 4'd6;
  localparam logic [3:0] PH_LH   = 4'd7;
  localparam logic [3:0] PH_LL   = 4'd8;
  localparam logic [3:0] PH_C25  = 4'd9;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        block_start;
    logic        block_last;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic        field_offset;
  } sbd_in_t;

  typedef struct packed {
    logic [3:0]  pcode;
    logic [8:0]  run_len;
    logic [15:0] x_start;
    logic [15:0] line;
    logic        last;
  } sbd_out_t;

  // One parsed byte: position changes and up to two runs, in order.
  typedef struct packed {
    logic        start;
    logic [11:0] origin_x;
    logic [15:0] start_line;
    logic        newline;
    logic        run0_v;
    logic [3:0]  run0_code;
    logic [8:0]  run0_len;
    logic        run1_v;
    logic [3:0]  run1_code;
    logic [8:0]  run1_len;
  } sbd_entry_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] pend;
    logic       emit;
    logic [3:0] code;
    logic [8:0] len;
    logic       eos;
  } sbd_nib_t;

  // Decodes one nibble of a 4-bit pixel code string.
  function automatic sbd_nib_t sbd_nibble_step(input logic [3:0] phase,
                                               input logic [7:0] pend,
                                               input logic [3:0] nib);
    sbd_nib_t r;
    r.phase = phase;
    r.pend  = pend;
    r.emit  = 1'b0;
    r.code  = nib;
    r.len   = 9'd1;
    r.eos   = 1'b0;
    case (phase)
      PH_CODE: begin
        if (nib != 4'd0) begin
          r.emit = 1'b1;
        end else begin
          r.phase = PH_SW;
        end
      end
      PH_SW: begin
        if (!nib[3]) begin
          if (nib[2:0] == 3'd0) begin
            r.phase = PH_IDLE;
            r.eos   = 1'b1;
          end else begin
            r.emit  = 1'b1;
            r.code  = 4'd0;
            r.len   = {6'd0, nib[2:0]} + 9'd2;
            r.phase = PH_CODE;
          end
        end else if (!nib[2]) begin
          r.pend  = {6'd0, nib[1:0]};
          r.phase = PH_C4;
        end else begin
          case (nib[1:0])
            2'd0: begin
              r.emit  = 1'b1;
              r.code  = 4'd0;
              r.len   = 9'd1;
              r.phase = PH_CODE;
            end
            2'd1: begin
              r.emit  = 1'b1;
              r.code  = 4'd0;
              r.len   = 9'd2;
              r.phase = PH_CODE;
            end
            2'd2: r.phase = PH_L9;
            default: r.phase = PH_LH;
          endcase
        end
      end
      PH_C4: begin
        r.emit  = 1'b1;
        r.len   = {1'b0, pend} + 9'd4;
        r.phase = PH_CODE;
      end
      PH_L9: begin
        r.pend  = {4'd0, nib};
        r.phase = PH_C9;
      end
      PH_C9: begin
        r.emit  = 1'b1;
        r.len   = {1'b0, pend} + 9'd9;
        r.phase = PH_CODE;
      end
      PH_LH: begin
        r.pend  = {nib, 4'd0};
        r.phase = PH_LL;
      end
      PH_LL: begin
        r.pend  = {pend[7:4], nib};
        r.phase = PH_C25;
      end
      PH_C25: begin
        r.emit  = 1'b1;
        r.len   = {1'b0, pend} + 9'd25;
        r.phase = PH_CODE;
      end
      default: r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/sbd_front.sv =====
// ----------------------------------------------------------------------------
// sbd_front
// Byte parser: classifies data types and decodes the two nibbles of a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire sbd_pkg::sbd_in_t   item,
  output sbd_pkg::sbd_entry_t     entry,
  output logic                    entry_push
);
  import sbd_pkg::*;

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [7:0] pend;
  logic [7:0] pend_next;
  logic [3:0] ph;
  sbd_nib_t   n1;
  sbd_nib_t   n2;

  always_comb begin
    ph = item.block_start ? PH_IDLE : phase;
    n1 = sbd_nibble_step(ph, pend, item.data_byte[7:4]);
    n2 = sbd_nibble_step(n1.phase, n1.pend, item.data_byte[3:0]);

    phase_next = PH_IDLE;
    pend_next  = pend;

    entry            = '0;
    entry.start      = item.block_start;
    entry.origin_x   = item.origin_x;
    entry.start_line = {4'd0, item.origin_y} + {15'd0, item.field_offset};

    if (ph == PH_SKIP) begin
      phase_next = PH_CODE;
    end else if (ph >= PH_CODE && ph <= PH_C25) begin
      if (n1.eos) begin
        phase_next = PH_IDLE;
        pend_next  = n1.pend;
      end else begin
        phase_next = n2.phase;
        pend_next  = n2.pend;
      end
      // The first run found in the byte always goes to slot 0.
      if (n1.emit) begin
        entry.run0_v    = 1'b1;
        entry.run0_code = n1.code;
        entry.run0_len  = n1.len;
        entry.run1_v    = !n1.eos && n2.emit;
        entry.run1_code = n2.code;
        entry.run1_len  = n2.len;
      end else if (!n1.eos && n2.emit) begin
        entry.run0_v    = 1'b1;
        entry.run0_code = n2.code;
        entry.run0_len  = n2.len;
      end
    end else begin
      case (item.data_byte)
        DT_STRING_4BIT: phase_next = PH_CODE;
        DT_SKIP_ONE:    phase_next = PH_SKIP;
        DT_END_OF_LINE: entry.newline = 1'b1;
        default:        phase_next = PH_IDLE;
      endcase
    end

    if (item.block_last) begin
      phase_next = PH_IDLE;
    end

    entry_push = accept && (entry.start || entry.newline || entry.run0_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pend  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      pend  <= pend_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sbd_queue.sv =====
// ----------------------------------------------------------------------------
// sbd_queue
// Short first-in first-out queue of parsed bytes between parser and placer.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_queue #(
  parameter int Depth = sbd_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sbd_pkg::sbd_entry_t wdata,
  output logic                     full,
  input  wire logic                pop,
  output sbd_pkg::sbd_entry_t      rdata,
  output logic                     empty
);
  import sbd_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

  sbd_entry_t    store [Depth];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sbd_back.sv =====
// ----------------------------------------------------------------------------
// sbd_back
// Run placer: tracks x and line, drops runs below the region, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         area_lines,
  input  wire sbd_pkg::sbd_entry_t entry,
  input  wire logic                entry_empty,
  output logic                     entry_pop,
  input  wire logic                pop,
  output logic                     empty,
  output sbd_pkg::sbd_out_t        result
);
  import sbd_pkg::*;

  logic [15:0] x_pos;
  logic [15:0] line_num;
  logic [11:0] saved_ox;
  logic        out_v;
  sbd_out_t    out_r;
  logic        hold_v;
  sbd_out_t    hold_r;

  logic        slot_free;
  logic [15:0] x_s;
  logic [15:0] line_s;
  logic [11:0] so_s;
  logic [15:0] x_e;
  logic [15:0] line_e;
  logic [15:0] x_mid;
  logic [15:0] x_new;
  logic        vis;
  sbd_out_t    r0;
  sbd_out_t    r1;

  assign empty     = !out_v;
  assign result    = out_r;
  assign slot_free = !out_v || pop;
  assign entry_pop = !hold_v && !entry_empty && slot_free;

  always_comb begin
    x_s    = entry.start ? {4'd0, entry.origin_x} : x_pos;
    line_s = entry.start ? entry.start_line : line_num;
    so_s   = entry.start ? entry.origin_x : saved_ox;
    x_e    = entry.newline ? {4'd0, so_s} : x_s;
    line_e = entry.newline ? line_s + 16'd2 : line_s;
    vis    = line_e < area_lines;

    x_mid  = x_e + (entry.run0_v ? {7'd0, entry.run0_len} : 16'd0);
    x_new  = x_mid + (entry.run1_v ? {7'd0, entry.run1_len} : 16'd0);

    r0.pcode   = entry.run0_code;
    r0.run_len = entry.run0_len;
    r0.x_start = x_e;
    r0.line    = line_e;
    r0.last    = !entry.run1_v;

    r1.pcode   = entry.run1_code;
    r1.run_len = entry.run1_len;
    r1.x_start = x_mid;
    r1.line    = line_e;
    r1.last    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (entry_pop) begin
      hold_r <= r1;
    end
    if (hold_v && slot_free) begin
      out_r <= hold_r;
    end else if (entry_pop) begin
      out_r <= r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos    <= '0;
      line_num <= '0;
      saved_ox <= '0;
      out_v    <= 1'b0;
      hold_v   <= 1'b0;
    end else begin
      if (hold_v && slot_free) begin
        out_v  <= 1'b1;
        hold_v <= 1'b0;
      end else if (entry_pop) begin
        x_pos    <= x_new;
        line_num <= line_e;
        saved_ox <= so_s;
        // Both runs of a byte share one line, so they are kept or dropped together.
        out_v  <= entry.run0_v && vis;
        hold_v <= entry.run1_v && vis;
      end else if (pop) begin
        out_v <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/subtitle_4bit_pixel_string_decoder.sv =====
// ----------------------------------------------------------------------------
// subtitle_4bit_pixel_string_decoder
// Parses pixel-data sub-block bytes and returns placed 4-bit pixel runs.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | push / full      | item   : byte, block marks, origin, field
//  result   | empty / pop      | result : code, length, x, line, last
//  config   | cfg_wen          | cfg_wdata : region height
//
//  A byte is parsed in the cycle it is accepted; one byte per cycle goes in
//  while full is low. The placer drives the two runs of a byte in turn and
//  takes no new byte meanwhile; the queue before the placer absorbs that.
//  A result passes through the queue and the result register to the ports.
//  Reset empties the queue and the result register; full is low after it.
//  When pop stays low, the result register and then the queue fill up.
// ----------------------------------------------------------------------------
`default_nettype none

module subtitle_4bit_pixel_string_decoder #(
  parameter int QueueDepth = sbd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire sbd_pkg::sbd_in_t  item,
  output logic                   empty,
  input  wire logic              pop,
  output sbd_pkg::sbd_out_t      result,
  input  wire logic              cfg_wen,
  input  wire logic [15:0]       cfg_wdata
);
  import sbd_pkg::*;

  logic [15:0] area_lines;
  sbd_entry_t  f_entry;
  logic        f_push;
  sbd_entry_t  q_entry;
  logic        q_empty;
  logic        q_pop;
  logic        accept;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_lines <= AREA_LINES_RESET;
    end else if (cfg_wen) begin
      area_lines <= cfg_wdata;
    end
  end

  sbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .entry      (f_entry),
    .entry_push (f_push)
  );

  sbd_queue #(.Depth(QueueDepth)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_entry),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_entry),
    .empty (q_empty)
  );

  sbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .area_lines  (area_lines),
    .entry       (q_entry),
    .entry_empty (q_empty),
    .entry_pop   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== design/sbd_checker.sv =====
// ----------------------------------------------------------------------------
// sbd_checker
// Port-level checks of the pixel string decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire sbd_pkg::sbd_out_t result
);
  import sbd_pkg::*;

  // Reset leaves nothing to read and room to write.
  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("outputs not cleared after reset");

  // A waiting result beat holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while waiting");

  // Run lengths stay in the range the codes can describe.
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.run_len != 9'd0 && result.run_len <= 9'd280))
    else $error("run length out of range");

  // The second run of a byte follows right after its first one is taken.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last) |=> (!empty && result.line == $past(result.line)))
    else $error("second run of a byte did not follow");

endmodule

bind subtitle_4bit_pixel_string_decoder sbd_checker u_sbd_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
